// ===== hdl/wdpr_pkg.sv =====
package wdpr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_WALL_HALF_SPAN = 3'd0;
  localparam logic [2:0] REG_RIGHT_ALONG    = 3'd1;
  localparam logic [2:0] REG_RIGHT_ACROSS   = 3'd2;
  localparam logic [2:0] REG_LEFT_ALONG     = 3'd3;
  localparam logic [2:0] REG_LEFT_ACROSS    = 3'd4;

  localparam logic [14:0] WALL_HALF_SPAN_RST = 15'd18176;
  localparam logic signed [13:0] RIGHT_ALONG_RST  = 14'sd640;
  localparam logic signed [13:0] RIGHT_ACROSS_RST = 14'sd128;
  localparam logic signed [13:0] LEFT_ALONG_RST   = 14'sd768;
  localparam logic signed [13:0] LEFT_ACROSS_RST  = -14'sd256;

  // n / 127 == (n * DIV127_RECIP) >> 31 for every n below 2^24
  localparam logic [24:0] DIV127_RECIP = 25'd16909321;
  // floor(2^16 / 90), estimate of hi / 90 low by at most one
  localparam logic [23:0] DIV90_RECIP = 24'd728;

  // angles in 1/256 degree
  localparam logic [16:0] DEG_45  = 17'd11520;
  localparam logic [16:0] DEG_90  = 17'd23040;
  localparam logic [16:0] DEG_135 = 17'd34560;
  localparam logic [16:0] DEG_225 = 17'd57600;
  localparam logic [16:0] DEG_270 = 17'd69120;
  localparam logic [16:0] DEG_315 = 17'd80640;
  localparam logic signed [17:0] DEG_180_S = 18'sd46080;
  localparam logic signed [17:0] DEG_360_S = 18'sd92160;
  // 2^23 mod 92160, and the turn less that offset
  localparam logic [16:0] HEAD_BIAS      = 17'd2048;
  localparam logic [16:0] TURN_LESS_BIAS = 17'd90112;

  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  typedef struct packed {
    logic [14:0]        wall_half_span;
    logic signed [13:0] right_along;
    logic signed [13:0] right_across;
    logic signed [13:0] left_along;
    logic signed [13:0] left_across;
  } cfg_t;

  typedef struct packed {
    logic               right;
    logic               on_x;
    logic               pos;
    logic               neg;
    logic signed [17:0] reach;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
  } side_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [25:0] z;
    side_t              side;
  } cordic_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_val(input int unsigned idx);
    case (idx)
      0:  return 22'd2949120;
      1:  return 22'd1740967;
      2:  return 22'd919879;
      3:  return 22'd466945;
      4:  return 22'd234379;
      5:  return 22'd117266;
      6:  return 22'd58666;
      7:  return 22'd29335;
      8:  return 22'd14668;
      9:  return 22'd7334;
      10: return 22'd3667;
      11: return 22'd1833;
      12: return 22'd917;
      13: return 22'd458;
      14: return 22'd229;
      15: return 22'd115;
      16: return 22'd57;
      17: return 22'd29;
      18: return 22'd14;
      19: return 22'd7;
      20: return 22'd4;
      21: return 22'd2;
      22: return 22'd1;
      default: return 22'd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sat_q15(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sd32767;
    end else if (v < -18'sd32767) begin
      return -16'sd32767;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sat_16(input logic signed [20:0] v);
    if (v > 21'sd32767) begin
      return 16'sh7fff;
    end else if (v < -21'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== hdl/wdpr_prep.sv =====
module wdpr_prep import wdpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [12:0]        range_mm_i,
  input  logic               use_right_sensor_i,
  input  logic signed [23:0] heading_i,
  input  logic signed [15:0] current_x_i,
  input  logic signed [15:0] current_y_i,
  input  cfg_t               cfg_i,
  output cordic_t            cord_o
);

  // stage A: mm to inch quotient, coarse heading quotient
  logic               a_valid_q;
  logic [16:0]        a_dq_q;
  logic [13:0]        a_hi_q;
  logic [7:0]         a_hq_q;
  logic [9:0]         a_lo_q;
  logic               a_right_q;
  logic signed [15:0] a_cx_q, a_cy_q;

  logic [23:0] a_num;
  logic [48:0] a_dprod;
  logic [23:0] a_hu;
  logic [23:0] a_hprod;

  always_comb begin
    a_num   = 24'({range_mm_i, 10'b0}) + 24'({range_mm_i, 8'b0}) + 24'd63;
    a_dprod = 49'(a_num) * 49'(DIV127_RECIP);
    // bias the heading by 2^23 so it is unsigned
    a_hu    = {~heading_i[23], heading_i[22:0]};
    a_hprod = 24'(a_hu[23:10]) * DIV90_RECIP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_dq_q    <= a_dprod[47:31];
    a_hi_q    <= a_hu[23:10];
    a_hq_q    <= a_hprod[23:16];
    a_lo_q    <= a_hu[9:0];
    a_right_q <= use_right_sensor_i;
    a_cx_q    <= current_x_i;
    a_cy_q    <= current_y_i;
  end

  // stage B: remainder mod 90 turns of 1024, distance plus offset
  logic               b_valid_q;
  logic [16:0]        b_rfull_q;
  logic signed [17:0] b_dist_q;
  logic               b_right_q;
  logic signed [15:0] b_cx_q, b_cy_q;

  logic [13:0]        b_rem;
  logic [13:0]        b_rem_c;
  logic signed [13:0] b_along;

  always_comb begin
    b_rem   = a_hi_q - 14'(a_hq_q) * 14'd90;
    b_rem_c = (b_rem >= 14'd90) ? b_rem - 14'd90 : b_rem;
    b_along = a_right_q ? cfg_i.right_along : cfg_i.left_along;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rfull_q <= {b_rem_c[6:0], a_lo_q};
    b_dist_q  <= $signed({1'b0, a_dq_q}) + 18'(b_along);
    b_right_q <= a_right_q;
    b_cx_q    <= a_cx_q;
    b_cy_q    <= a_cy_q;
  end

  // stage C: drop the bias, heading now 0..360 degrees
  logic               c_valid_q;
  logic [16:0]        c_ang_q;
  logic signed [17:0] c_dist_q;
  logic               c_right_q;
  logic signed [15:0] c_cx_q, c_cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_ang_q   <= (b_rfull_q >= HEAD_BIAS) ? b_rfull_q - HEAD_BIAS
                                          : b_rfull_q + TURN_LESS_BIAS;
    c_dist_q  <= b_dist_q;
    c_right_q <= b_right_q;
    c_cx_q    <= b_cx_q;
    c_cy_q    <= b_cy_q;
  end

  // stage D: sector decode and fold into -90..90 for the rotator
  logic               d_valid_q;
  cordic_t            d_data_q;
  cordic_t            d_data;
  logic signed [17:0] d_red;
  logic               d_east;

  always_comb begin
    d_east = (c_ang_q >= DEG_315) || (c_ang_q < DEG_45);
    if (c_ang_q <= DEG_90) begin
      d_red = $signed({1'b0, c_ang_q});
    end else if (c_ang_q < DEG_270) begin
      d_red = $signed({1'b0, c_ang_q}) - DEG_180_S;
    end else begin
      d_red = $signed({1'b0, c_ang_q}) - DEG_360_S;
    end
    d_data            = '0;
    d_data.x          = CORDIC_X0;
    d_data.y          = '0;
    d_data.z          = $signed({d_red, 8'b0});
    d_data.side.right = c_right_q;
    d_data.side.on_x  = d_east || ((c_ang_q >= DEG_135) && (c_ang_q < DEG_225));
    d_data.side.pos   = (d_east || ((c_ang_q >= DEG_225) && (c_ang_q < DEG_315)))
                        ^ ~c_right_q;
    d_data.side.neg   = (c_ang_q > DEG_90) && (c_ang_q < DEG_270);
    d_data.side.reach = c_dist_q;
    d_data.side.cur_x = c_cx_q;
    d_data.side.cur_y = c_cy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_data_q <= d_data;
  end

  always_comb begin
    cord_o       = d_data_q;
    cord_o.valid = d_valid_q;
  end

endmodule

// ===== hdl/wdpr_cordic_cell.sv =====
module wdpr_cordic_cell import wdpr_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cordic_t cell_i,
  output cordic_t cell_o
);

  localparam logic signed [25:0] ATAN = $signed({4'b0000, atan_val(STAGE)});

  cordic_t            cell_d;
  cordic_t            data_q;
  logic               valid_q;
  logic signed [31:0] x_sh, y_sh;

  always_comb begin
    x_sh   = $signed(cell_i.x) >>> STAGE;
    y_sh   = $signed(cell_i.y) >>> STAGE;
    cell_d = cell_i;
    // rotate toward zero residual angle
    if (!cell_i.z[25]) begin
      cell_d.x = cell_i.x - y_sh;
      cell_d.y = cell_i.y + x_sh;
      cell_d.z = cell_i.z - ATAN;
    end else begin
      cell_d.x = cell_i.x + y_sh;
      cell_d.y = cell_i.y - x_sh;
      cell_d.z = cell_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= cell_d;
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

// ===== hdl/wdpr_post.sv =====
module wdpr_post import wdpr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cordic_t            cord_i,
  input  cfg_t               cfg_i,
  output logic               done_o,
  output logic               on_x_axis_o,
  output logic signed [15:0] reset_position_o,
  output logic signed [15:0] new_x_o,
  output logic signed [15:0] new_y_o
);

  // stage E: round to Q1.15, clamp, undo the half-turn fold
  logic               e_valid_q;
  logic signed [15:0] e_c_q, e_s_q;
  side_t              e_side_q;

  logic signed [32:0] e_xs, e_ys;
  logic signed [15:0] e_c, e_s;

  always_comb begin
    e_xs = 33'(cord_i.x) + 33'sd16384;
    e_ys = 33'(cord_i.y) + 33'sd16384;
    e_c  = sat_q15(e_xs[32:15]);
    e_s  = sat_q15(e_ys[32:15]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= cord_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    e_c_q    <= cord_i.side.neg ? -e_c : e_c;
    e_s_q    <= cord_i.side.neg ? -e_s : e_s;
    e_side_q <= cord_i.side;
  end

  // stage F: products for the selected axis
  logic               f_valid_q;
  logic signed [33:0] f_pd_q;
  logic signed [29:0] f_pa_q, f_pb_q;
  side_t              f_side_q;

  logic signed [15:0] f_t, f_tabs, f_ta, f_tb;
  logic signed [13:0] f_along, f_across;

  always_comb begin
    f_t      = e_side_q.on_x ? e_c_q : e_s_q;
    f_tabs   = f_t[15] ? -f_t : f_t;
    f_ta     = e_side_q.on_x ? e_c_q : e_s_q;
    f_tb     = e_side_q.on_x ? -e_s_q : e_c_q;
    f_along  = e_side_q.right ? cfg_i.right_along : cfg_i.left_along;
    f_across = e_side_q.right ? cfg_i.right_across : cfg_i.left_across;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_pd_q   <= e_side_q.reach * f_tabs;
    f_pa_q   <= f_along * f_ta;
    f_pb_q   <= f_across * f_tb;
    f_side_q <= e_side_q;
  end

  // stage G: rotated offset
  logic               g_valid_q;
  logic signed [33:0] g_pd_q;
  logic signed [30:0] g_rot_q;
  side_t              g_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else begin
      g_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    g_pd_q   <= f_pd_q;
    g_rot_q  <= 31'(f_pa_q) + 31'(f_pb_q);
    g_side_q <= f_side_q;
  end

  // stage H: corrected distance, rounded half up to 1/256 inch
  logic               h_valid_q;
  logic signed [19:0] h_corr_q;
  side_t              h_side_q;

  logic signed [30:0] h_rot_abs;
  logic signed [34:0] h_raw;

  always_comb begin
    h_rot_abs = g_rot_q[30] ? -g_rot_q : g_rot_q;
    h_raw     = 35'(g_pd_q) + 35'(h_rot_abs) + 35'sd16384;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else begin
      h_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h_corr_q <= h_raw[34:15];
    h_side_q <= g_side_q;
  end

  // stage I: snap to the wall and drive the result beat
  logic               done_q;
  logic               on_x_q;
  logic signed [15:0] pos_q, nx_q, ny_q;

  logic signed [20:0] i_fin;
  logic signed [15:0] i_sat;

  always_comb begin
    i_fin = 21'($signed({1'b0, cfg_i.wall_half_span})) - 21'(h_corr_q);
    if (!h_side_q.pos) begin
      i_fin = -i_fin;
    end
    i_sat = sat_16(i_fin);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= h_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    on_x_q <= h_side_q.on_x;
    pos_q  <= i_sat;
    nx_q   <= h_side_q.on_x ? i_sat : h_side_q.cur_x;
    ny_q   <= h_side_q.on_x ? h_side_q.cur_y : i_sat;
  end

  assign done_o           = done_q;
  assign on_x_axis_o      = on_x_q;
  assign reset_position_o = pos_q;
  assign new_x_o          = nx_q;
  assign new_y_o          = ny_q;

endmodule

// ===== hdl/wall_distance_pose_reset.sv =====
// Wall distance pose reset.
// Input: one beat is taken at each rising edge with start_i high and busy_o
// low. busy_o stays low, so a new reading may be issued every cycle.
// A beat carries range_mm_i, use_right_sensor_i, heading_i, current_x_i and
// current_y_i.
// Output: each beat yields one result, shown for a single cycle with done_o
// high on on_x_axis_o, reset_position_o, new_x_o and new_y_o. The receiver
// cannot stall; take the result in the cycle done_o is high.
// Throughput: one beat per cycle. A beat passes the prep stages A to D
// (inch conversion and heading wrap), the chain of rotator cells, one cell
// per CORDIC iteration, and the post stages E to I (the product and
// rounding steps and the snap) before done_o goes high.
// Configuration: write cfg_wdata_i into register cfg_idx_i at an edge with
// cfg_we_i high, only while no result is still outstanding. Unknown indexes
// are dropped.
// Reset: rst_ni low clears every stage valid bit, so no stray result
// appears, and returns the configuration registers to their reset values.
module wall_distance_pose_reset import wdpr_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [12:0]        range_mm_i,
  input  logic               use_right_sensor_i,
  input  logic signed [23:0] heading_i,
  input  logic signed [15:0] current_x_i,
  input  logic signed [15:0] current_y_i,
  output logic               done_o,
  output logic               on_x_axis_o,
  output logic signed [15:0] reset_position_o,
  output logic signed [15:0] new_x_o,
  output logic signed [15:0] new_y_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [14:0]        cfg_wdata_i
);

  localparam int unsigned LATENCY = CORDIC_STAGES + 9;

  cfg_t    cfg_q;
  logic    accept;
  cordic_t chain [CORDIC_STAGES + 1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wall_half_span <= WALL_HALF_SPAN_RST;
      cfg_q.right_along    <= RIGHT_ALONG_RST;
      cfg_q.right_across   <= RIGHT_ACROSS_RST;
      cfg_q.left_along     <= LEFT_ALONG_RST;
      cfg_q.left_across    <= LEFT_ACROSS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WALL_HALF_SPAN: cfg_q.wall_half_span <= cfg_wdata_i;
        REG_RIGHT_ALONG:    cfg_q.right_along    <= cfg_wdata_i[13:0];
        REG_RIGHT_ACROSS:   cfg_q.right_across   <= cfg_wdata_i[13:0];
        REG_LEFT_ALONG:     cfg_q.left_along     <= cfg_wdata_i[13:0];
        REG_LEFT_ACROSS:    cfg_q.left_across    <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  wdpr_prep u_prep (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .range_mm_i         (range_mm_i),
    .use_right_sensor_i (use_right_sensor_i),
    .heading_i          (heading_i),
    .current_x_i        (current_x_i),
    .current_y_i        (current_y_i),
    .cfg_i              (cfg_q),
    .cord_o             (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    wdpr_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  wdpr_post u_post (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cord_i           (chain[CORDIC_STAGES]),
    .cfg_i            (cfg_q),
    .done_o           (done_o),
    .on_x_axis_o      (on_x_axis_o),
    .reset_position_o (reset_position_o),
    .new_x_o          (new_x_o),
    .new_y_o          (new_y_o)
  );

  // every accepted beat comes out after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("accepted beat did not produce a result");

  // no result without a beat accepted the latency before
  a_latency_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without a matching accepted beat");

  // the snapped coordinate lands on the axis that was reset
  a_axis_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (on_x_axis_o ? (new_x_o == reset_position_o)
                            : (new_y_o == reset_position_o)))
    else $error("snapped coordinate not on the selected axis");

endmodule

// ===== dv/wall_distance_pose_reset_test.sv =====
`timescale 1ns / 1ps

module wall_distance_pose_reset_test import wdpr_pkg::*;;

  localparam int unsigned CORDIC_STAGES = 16;
  localparam int LATENCY = CORDIC_STAGES + 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_BEATS = 250;

  // angles in 1/256 degree
  localparam int OCTANT = 11520;
  localparam int QUARTER = 23040;
  localparam int TURN = 92160;

  localparam longint CORDIC_START = 652032874;
  localparam longint ATAN_STEP [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [12:0]        range_mm;
    logic               right;
    logic signed [23:0] heading;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } reading_t;

  typedef struct packed {
    logic               on_x;
    logic signed [15:0] pos;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } snap_t;

  typedef struct packed {
    reading_t rd;
    logic     typed;
    snap_t    want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 22;
  // rows 1 to 5 saturate, so their results are typed in
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{13'd0,    1'b1, 24'sd0,     16'sh8000, 16'sd32767}, 1'b0, '0},
    '{'{13'd8191, 1'b1, 24'sd0,     16'sd1234, 16'sh8000},
      1'b1, '{1'b1, 16'sh8000, 16'sh8000, 16'sh8000}},
    '{'{13'd8191, 1'b0, 24'sd0,     -16'sd5,   16'sd32767},
      1'b1, '{1'b1, 16'sd32767, 16'sd32767, 16'sd32767}},
    '{'{13'd8191, 1'b1, 24'sd23040, -16'sd1,   16'sd77},
      1'b1, '{1'b0, 16'sd32767, -16'sd1, 16'sd32767}},
    '{'{13'd8191, 1'b1, 24'sd46080, 16'sd0,    16'sh8000},
      1'b1, '{1'b1, 16'sd32767, 16'sd32767, 16'sh8000}},
    '{'{13'd8191, 1'b0, 24'sd69120, 16'sd32767, 16'sd0},
      1'b1, '{1'b0, 16'sd32767, 16'sd32767, 16'sd32767}},
    '{'{13'd100,  1'b1, 24'sd11520, 16'sd100,  -16'sd100}, 1'b0, '0},
    '{'{13'd100,  1'b0, 24'sd11519, 16'sd200,  -16'sd200}, 1'b0, '0},
    '{'{13'd700,  1'b1, 24'sd34560, -16'sd300, 16'sd300},  1'b0, '0},
    '{'{13'd700,  1'b0, 24'sd34559, 16'sd0,    16'sd0},    1'b0, '0},
    '{'{13'd1500, 1'b1, 24'sd57600, 16'sd4096, 16'sd4096}, 1'b0, '0},
    '{'{13'd1500, 1'b0, 24'sd57599, 16'sd1,    16'sd2},    1'b0, '0},
    '{'{13'd250,  1'b1, 24'sd80640, -16'sd77,  16'sd33},   1'b0, '0},
    '{'{13'd250,  1'b0, 24'sd80639, 16'sd9999, -16'sd9999}, 1'b0, '0},
    '{'{13'd42,   1'b1, 24'sd92159, 16'sd5,    16'sd6},    1'b0, '0},
    '{'{13'd4095, 1'b0, 24'sh800000, 16'sd32767, 16'sh8000}, 1'b0, '0},
    '{'{13'd4096, 1'b1, 24'sh7fffff, 16'sh8000, 16'sd32767}, 1'b0, '0},
    '{'{13'd300,  1'b1, -24'sd1,    16'sd12,   16'sd13},   1'b0, '0},
    '{'{13'd300,  1'b0, 24'sd69120, 16'sd14,   16'sd15},   1'b0, '0},
    '{'{13'd300,  1'b1, 24'sd69119, 16'sd16,   16'sd17},   1'b0, '0},
    '{'{13'd300,  1'b0, 24'sd23041, 16'sd18,   16'sd19},   1'b0, '0},
    '{'{13'd1,    1'b0, 24'sd5000,  -16'sd20,  -16'sd21},  1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [12:0]        range_mm_i;
  logic               use_right_sensor_i;
  logic signed [23:0] heading_i;
  logic signed [15:0] current_x_i;
  logic signed [15:0] current_y_i;
  logic               done_o;
  logic               on_x_axis_o;
  logic signed [15:0] reset_position_o;
  logic signed [15:0] new_x_o;
  logic signed [15:0] new_y_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [14:0]        cfg_wdata_i;

  wall_distance_pose_reset #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .range_mm_i        (range_mm_i),
    .use_right_sensor_i(use_right_sensor_i),
    .heading_i         (heading_i),
    .current_x_i       (current_x_i),
    .current_y_i       (current_y_i),
    .done_o            (done_o),
    .on_x_axis_o       (on_x_axis_o),
    .reset_position_o  (reset_position_o),
    .new_x_o           (new_x_o),
    .new_y_o           (new_y_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  // mirror of the register file
  longint wall_span = WALL_HALF_SPAN_RST;
  longint right_along = RIGHT_ALONG_RST;
  longint right_across = RIGHT_ACROSS_RST;
  longint left_along = LEFT_ALONG_RST;
  longint left_across = LEFT_ACROSS_RST;

  snap_t snaps_due [$];
  int    errors = 0;
  int    snaps_checked = 0;
  int    x_snaps = 0;
  int    saturated = 0;
  int    idle_cycles = 0;
  int    burst_left = 1;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic snap_t predict_snap(reading_t r);
    longint along, across, reach, ang, rot, vx, vy, nx, z, s, c, rx, ry, raw, corr, fin;
    logic   on_x, pos, neg;
    snap_t  o;
    along  = r.right ? right_along : left_along;
    across = r.right ? right_across : left_across;
    reach  = (longint'(r.range_mm) * 1280 + 63) / 127 + along;

    ang = longint'(r.heading) % TURN;
    if (ang < 0) begin
      ang += TURN;
    end
    on_x = (ang >= 7 * OCTANT || ang < OCTANT) || (ang >= 3 * OCTANT && ang < 5 * OCTANT);
    pos  = (ang >= 7 * OCTANT || ang < OCTANT) || (ang >= 5 * OCTANT && ang < 7 * OCTANT);
    if (!r.right) begin
      pos = !pos;
    end

    // fold into -90..90 degrees, then rotate
    neg = 1'b0;
    if (ang <= QUARTER) begin
      rot = ang;
    end else if (ang < 3 * QUARTER) begin
      rot = ang - 2 * QUARTER;
      neg = 1'b1;
    end else begin
      rot = ang - TURN;
    end
    z  = rot * 256;
    vx = CORDIC_START;
    vy = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      if (z >= 0) begin
        nx = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        z -= ATAN_STEP[i];
      end else begin
        nx = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        z += ATAN_STEP[i];
      end
      vx = nx;
    end
    c = clamp_to((vx + 16384) >>> 15, -32767, 32767);
    s = clamp_to((vy + 16384) >>> 15, -32767, 32767);
    if (neg) begin
      c = -c;
      s = -s;
    end

    rx = along * c - across * s;
    ry = along * s + across * c;
    if (on_x) begin
      raw = reach * (c < 0 ? -c : c) + (rx < 0 ? -rx : rx);
    end else begin
      raw = reach * (s < 0 ? -s : s) + (ry < 0 ? -ry : ry);
    end
    corr = (raw + 16384) >>> 15;
    fin  = wall_span - corr;
    if (!pos) begin
      fin = -fin;
    end
    fin = clamp_to(fin, -32768, 32767);

    o.on_x = on_x;
    o.pos  = 16'(fin);
    o.nx   = on_x ? 16'(fin) : r.x;
    o.ny   = on_x ? r.y : 16'(fin);
    return o;
  endfunction

  // caller sits on a rising edge; leaves cfg_we_i high
  task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_WALL_HALF_SPAN: wall_span = longint'(data);
      REG_RIGHT_ALONG:    right_along = longint'($signed(data[13:0]));
      REG_RIGHT_ACROSS:   right_across = longint'($signed(data[13:0]));
      REG_LEFT_ALONG:     left_along = longint'($signed(data[13:0]));
      REG_LEFT_ACROSS:    left_across = longint'($signed(data[13:0]));
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (snaps_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // hold the beat until taken, then book its result and maybe open a gap
  task automatic drive_beat(input reading_t r, input logic typed, input snap_t want);
    int gap;
    start_i            <= 1'b1;
    range_mm_i         <= r.range_mm;
    use_right_sensor_i <= r.right;
    heading_i          <= r.heading;
    current_x_i        <= r.x;
    current_y_i        <= r.y;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    snaps_due.push_back(typed ? want : predict_snap(r));
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    snap_t want;
    if (rst_ni && done_o) begin
      if (snaps_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got pos %0d x %0d y %0d",
                 $time, reset_position_o, new_x_o, new_y_o);
      end else begin
        want = snaps_due.pop_front();
        check_field("on_x_axis", int'(want.on_x), int'(on_x_axis_o));
        check_field("reset_position", int'(want.pos), int'(reset_position_o));
        check_field("new_x", int'(want.nx), int'(new_x_o));
        check_field("new_y", int'(want.ny), int'(new_y_o));
        snaps_checked++;
        if (on_x_axis_o) begin
          x_snaps++;
        end
        if (reset_position_o == 16'sd32767 || reset_position_o == 16'sh8000) begin
          saturated++;
        end
      end
    end
  end

  // count cycles in which no beat moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reading_t    rd;
    logic [14:0] cfg_vals [5];
    int          sel;

    rst_ni             <= 1'b0;
    start_i            <= 1'b0;
    range_mm_i         <= '0;
    use_right_sensor_i <= 1'b0;
    heading_i          <= '0;
    current_x_i        <= '0;
    current_y_i        <= '0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= '0;
    cfg_wdata_i        <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < NUM_DIRECTED; k++) begin
      drive_beat(DIRECTED[k].rd, DIRECTED[k].typed, DIRECTED[k].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          cfg_vals[0] = '0;
          for (int k = 1; k < 5; k++) cfg_vals[k] = {1'($urandom), 14'h2000};
        end
        1: begin
          cfg_vals[0] = 15'h7fff;
          for (int k = 1; k < 5; k++) cfg_vals[k] = {1'($urandom), 14'h1fff};
        end
        2: begin
          cfg_vals[0] = 15'($urandom);
          for (int k = 1; k < 5; k++) cfg_vals[k] = {1'($urandom), 14'h0};
        end
        default: begin
          for (int k = 0; k < 5; k++) cfg_vals[k] = 15'($urandom);
        end
      endcase
      for (int k = int'(REG_WALL_HALF_SPAN); k <= int'(REG_LEFT_ACROSS); k++) begin
        write_reg(3'(k), cfg_vals[k]);
      end
      // writes to unmapped indexes must be dropped
      if (ph == 0) begin
        for (int k = int'(REG_LEFT_ACROSS) + 1; k < 8; k++) begin
          write_reg(3'(k), 15'($urandom));
        end
      end
      cfg_we_i <= 1'b0;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        sel = $urandom_range(0, 7);
        if (sel < 2) begin
          rd.range_mm = 13'($urandom_range(0, 15));
        end else if (sel == 2) begin
          rd.range_mm = 13'($urandom_range(8176, 8191));
        end else begin
          rd.range_mm = 13'($urandom);
        end
        rd.right = 1'($urandom);
        sel = $urandom_range(0, 3);
        case (sel)
          0: rd.heading = 24'($urandom);
          // hug a sector border, up to 90 turns away
          1: rd.heading = 24'(int'($urandom_range(0, 7)) * OCTANT
                              + int'($urandom_range(0, 6)) - 3
                              + (int'($urandom_range(0, 179)) - 90) * TURN);
          default: rd.heading = 24'($urandom_range(0, TURN - 1));
        endcase
        rd.x = 16'($urandom);
        rd.y = 16'($urandom);
        drive_beat(rd, 1'b0, '0);
        if (ph == 3 && n == PHASE_BEATS / 2) begin
          // drain the pipe before the next beat
          start_i <= 1'b0;
          while (snaps_due.size() != 0) begin
            @(posedge clk_i);
          end
        end
      end
    end

    wait_idle();
    $display("Summary: %0d snaps checked over %0d register settings plus reset values",
             snaps_checked, NUM_PHASES);
    $display("Summary: %0d on the x axis, %0d on the y axis, %0d saturated, %0d mismatches",
             x_snaps, snaps_checked - x_snaps, saturated, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wdpr_pkg.sv
hdl/wdpr_prep.sv
hdl/wdpr_cordic_cell.sv
hdl/wdpr_post.sv
hdl/wall_distance_pose_reset.sv
dv/wall_distance_pose_reset_test.sv
